// ===== hw/rtl/ptf_pkg.sv =====
// ----------------------------------------------------------------------------
// ptf_pkg
// Shared constants, register map, configuration type and the coordinate
// wrap function of the paletted texel fetch block.
// ----------------------------------------------------------------------------
package ptf_pkg;

  localparam int VramColumnsDef = 1024;
  localparam int VramRowsDef    = 512;
  localparam int QueueDepth     = 2;

  localparam int CfgAddrW = 5;
  localparam int RegIdxW  = 3;

  localparam logic [RegIdxW-1:0] RegTextureMode  = 3'd0;
  localparam logic [RegIdxW-1:0] RegPageBaseX    = 3'd1;
  localparam logic [RegIdxW-1:0] RegPageBaseY    = 3'd2;
  localparam logic [RegIdxW-1:0] RegPaletteBaseX = 3'd3;
  localparam logic [RegIdxW-1:0] RegPaletteBaseY = 3'd4;
  localparam logic [RegIdxW-1:0] RegWindowMasks  = 3'd5;
  localparam logic [RegIdxW-1:0] RegSemiEnable   = 3'd6;

  localparam logic [1:0] ModePal4   = 2'd0;
  localparam logic [1:0] ModePal8   = 2'd1;
  localparam logic [1:0] ModeDirect = 2'd2;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncFetch = 1'b1;

  localparam logic [31:0] WindowMasksRst = 32'h0000_FFFF;
  localparam logic [7:0]  AlphaHalf      = 8'd128;
  localparam logic [7:0]  AlphaFull      = 8'd255;

  // base of up to 10 bits plus an offset of up to 8 bits
  localparam int WrapW     = 11;
  localparam int WrapSteps = 5;

  typedef struct packed {
    logic [1:0]  tex_format;
    logic [9:0]  page_base_x;
    logic [8:0]  page_base_y;
    logic [9:0]  palette_base_x;
    logic [8:0]  palette_base_y;
    logic [31:0] window_masks;
    logic        semi_en;
  } ptf_cfg_t;

  // restoring reduction modulo a constant of at least 64
  function automatic logic [WrapW-1:0] wrap_coord(input logic [WrapW-1:0] x,
                                                  input int unsigned m);
    logic [31:0] r;
    r = 32'(x);
    for (int k = WrapSteps - 1; k >= 0; k--) begin
      if (r >= (m << k)) begin
        r = r - (m << k);
      end
    end
    return r[WrapW-1:0];
  endfunction

endpackage

// ===== hw/rtl/ptf_front.sv =====
// ----------------------------------------------------------------------------
// ptf_front
// Classifies an incoming item, applies the texture window and forms the
// wrapped video memory address of the write or of the texture page read.
// ----------------------------------------------------------------------------
module ptf_front #(
  parameter  int VRAM_COLUMNS = ptf_pkg::VramColumnsDef,
  parameter  int VRAM_ROWS    = ptf_pkg::VramRowsDef,
  localparam int AddrW        = $clog2(VRAM_COLUMNS * VRAM_ROWS),
  localparam int EntW         = AddrW + 19
) (
  input  ptf_pkg::ptf_cfg_t cfg,
  input  logic              in_func,
  input  logic [9:0]        in_vram_x,
  input  logic [8:0]        in_vram_y,
  input  logic [15:0]       in_write_data,
  input  logic [7:0]        in_tex_u,
  input  logic [7:0]        in_tex_v,
  output logic [EntW-1:0]   ent
);
  import ptf_pkg::*;

  logic [7:0]       u_win;
  logic [7:0]       v_win;
  logic [WrapW-1:0] col_sum;
  logic [WrapW-1:0] row_sum;
  logic [WrapW-1:0] col_w;
  logic [WrapW-1:0] row_w;
  logic [AddrW-1:0] addr;

  always_comb begin
    u_win = (in_tex_u & cfg.window_masks[7:0]) | cfg.window_masks[23:16];
    v_win = (in_tex_v & cfg.window_masks[15:8]) | cfg.window_masks[31:24];
    if (in_func == FuncWrite) begin
      col_sum = WrapW'(in_vram_x);
      row_sum = WrapW'(in_vram_y);
    end else begin
      case (cfg.tex_format)
        ModePal4: col_sum = WrapW'(cfg.page_base_x) + WrapW'(u_win[7:2]);
        ModePal8: col_sum = WrapW'(cfg.page_base_x) + WrapW'(u_win[7:1]);
        default:  col_sum = WrapW'(cfg.page_base_x) + WrapW'(u_win);
      endcase
      row_sum = WrapW'(cfg.page_base_y) + WrapW'(v_win);
    end
    col_w = wrap_coord(col_sum, VRAM_COLUMNS);
    row_w = wrap_coord(row_sum, VRAM_ROWS);
    addr  = AddrW'(32'(row_w) * 32'(VRAM_COLUMNS) + 32'(col_w));
  end

  assign ent = {in_func, u_win[1:0], in_write_data, addr};

endmodule

// ===== hw/rtl/ptf_queue.sv =====
// ----------------------------------------------------------------------------
// ptf_queue
// Short first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module ptf_queue #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = ptf_pkg::QueueDepth,
  localparam int PtrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CntW  = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] head_data
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r;
  logic [PtrW-1:0]  wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r;
  logic [PtrW-1:0]  rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r;
  logic [CntW-1:0]  cnt_nxt;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign full      = (cnt_r == CntW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_data = slot_r[rd_ptr_r];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into a full queue");

  a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == CntW'($past(cnt_r) + 1'b1)))
    else $error("queue count lost a push");

endmodule

// ===== hw/rtl/ptf_back.sv =====
// ----------------------------------------------------------------------------
// ptf_back
// Video memory with one write and two read ports: page read and write at the
// queue head, palette read one stage later, colour select and RGBA expansion
// into the output register.
// ----------------------------------------------------------------------------
module ptf_back #(
  parameter  int VRAM_COLUMNS = ptf_pkg::VramColumnsDef,
  parameter  int VRAM_ROWS    = ptf_pkg::VramRowsDef,
  localparam int Depth        = VRAM_COLUMNS * VRAM_ROWS,
  localparam int AddrW        = $clog2(Depth),
  localparam int EntW         = AddrW + 19
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ptf_pkg::ptf_cfg_t cfg,
  input  logic              q_valid,
  input  logic [EntW-1:0]   q_ent,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_raw_color,
  output logic [31:0]       out_texel_rgba
);
  import ptf_pkg::*;

  logic [15:0]      vram [Depth];

  logic             en;
  logic             q_func;
  logic [1:0]       q_sub;
  logic [15:0]      q_wdata;
  logic [AddrW-1:0] q_addr;

  logic             s1_valid_r;
  logic             s1_func_r;
  logic [1:0]       s1_sub_r;
  logic [15:0]      page_rd_r;

  logic [7:0]       pal_idx;
  logic [WrapW-1:0] pal_col;
  logic [WrapW-1:0] pal_row;
  logic [AddrW-1:0] pal_addr;

  logic             s2_valid_r;
  logic [15:0]      page_s2_r;
  logic [15:0]      pal_rd_r;

  logic             direct;
  logic [15:0]      color;
  logic [7:0]       alpha;
  logic [31:0]      rgba;

  logic             out_valid_r;
  logic [15:0]      out_raw_color_r;
  logic [31:0]      out_texel_rgba_r;

  function automatic logic [7:0] expand5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  assign en    = !out_valid_r || !out_stall;
  assign q_pop = q_valid && en;

  assign q_addr  = q_ent[AddrW-1:0];
  assign q_wdata = q_ent[AddrW+15:AddrW];
  assign q_sub   = q_ent[AddrW+17:AddrW+16];
  assign q_func  = q_ent[AddrW+18];

  always_comb begin
    case (cfg.tex_format)
      ModePal4: pal_idx = {4'h0, page_rd_r[{s1_sub_r, 2'b00} +: 4]};
      ModePal8: pal_idx = s1_sub_r[0] ? page_rd_r[15:8] : page_rd_r[7:0];
      default:  pal_idx = '0;
    endcase
    pal_col  = wrap_coord(WrapW'(cfg.palette_base_x) + WrapW'(pal_idx), VRAM_COLUMNS);
    pal_row  = wrap_coord(WrapW'(cfg.palette_base_y), VRAM_ROWS);
    pal_addr = AddrW'(32'(pal_row) * 32'(VRAM_COLUMNS) + 32'(pal_col));
  end

  // writes land with the page read of the next item; palette reads see old data
  always_ff @(posedge clk) begin
    if (en) begin
      if (q_pop && q_func == FuncWrite) begin
        vram[q_addr] <= q_wdata;
      end
      page_rd_r <= vram[q_addr];
      pal_rd_r  <= vram[pal_addr];
    end
  end

  always_comb begin
    direct = !(cfg.tex_format inside {ModePal4, ModePal8});
    color  = direct ? page_s2_r : pal_rd_r;
    alpha  = (cfg.semi_en && color[15]) ? AlphaHalf : AlphaFull;
    if (color == 16'h0000) begin
      rgba = '0;
    end else begin
      rgba = {alpha, expand5(color[14:10]), expand5(color[9:5]), expand5(color[4:0])};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= q_pop;
      s2_valid_r  <= s1_valid_r && (s1_func_r == FuncFetch);
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_func_r        <= q_func;
      s1_sub_r         <= q_sub;
      page_s2_r        <= page_rd_r;
      out_raw_color_r  <= color;
      out_texel_rgba_r <= rgba;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_raw_color  = out_raw_color_r;
  assign out_texel_rgba = out_texel_rgba_r;

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s1_valid_r && s1_func_r == FuncWrite) |=> !s2_valid_r)
    else $error("write item produced a result");

  a_hold_stages: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(s1_valid_r) && $stable(s2_valid_r)))
    else $error("pipeline moved while stalled");

  a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s2_valid_r) |=> out_valid_r)
    else $error("fetch result dropped");

endmodule

// ===== hw/rtl/paletted_texel_fetch_core.sv =====
// ----------------------------------------------------------------------------
// paletted_texel_fetch_core
// Paletted texel fetch with its own 16-bit video memory and register port.
// ----------------------------------------------------------------------------
// Throughput is one item per cycle, writes and fetches alike, while out_stall is
// low: the video memory has one write port and two read ports, so the texture
// page read of one fetch and the palette read of the fetch ahead of it happen in
// the same cycle. A fetch result passes from the queue through the page read,
// the palette read and the output register; a write gives no result.
// Video memory is not cleared at reset: read only words that were written.
// Registers lie at byte address 4*i; the user must write them only while the
// block is idle, and the block itself does not enforce this.
module paletted_texel_fetch_core #(
  parameter int VRAM_COLUMNS = ptf_pkg::VramColumnsDef,
  parameter int VRAM_ROWS    = ptf_pkg::VramRowsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ptf_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_func,
  input  logic [9:0]                   in_vram_x,
  input  logic [8:0]                   in_vram_y,
  input  logic [15:0]                  in_write_data,
  input  logic [7:0]                   in_tex_u,
  input  logic [7:0]                   in_tex_v,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [15:0]                  out_raw_color,
  output logic [31:0]                  out_texel_rgba
);
  import ptf_pkg::*;

  localparam int AddrW = $clog2(VRAM_COLUMNS * VRAM_ROWS);
  localparam int EntW  = AddrW + 19;

  ptf_cfg_t         cfg_r;
  logic [RegIdxW-1:0] reg_idx;
  logic             cfg_wr;

  logic [EntW-1:0]  front_ent;
  logic [EntW-1:0]  q_head;
  logic             q_full;
  logic             q_valid;
  logic             q_push;
  logic             q_pop;

  assign reg_idx = paddr[CfgAddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tex_format     <= ModePal4;
      cfg_r.page_base_x    <= '0;
      cfg_r.page_base_y    <= '0;
      cfg_r.palette_base_x <= '0;
      cfg_r.palette_base_y <= '0;
      cfg_r.window_masks   <= WindowMasksRst;
      cfg_r.semi_en        <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegTextureMode:  cfg_r.tex_format     <= pwdata[1:0];
        RegPageBaseX:    cfg_r.page_base_x    <= pwdata[9:0];
        RegPageBaseY:    cfg_r.page_base_y    <= pwdata[8:0];
        RegPaletteBaseX: cfg_r.palette_base_x <= pwdata[9:0];
        RegPaletteBaseY: cfg_r.palette_base_y <= pwdata[8:0];
        RegWindowMasks:  cfg_r.window_masks   <= pwdata;
        RegSemiEnable:   cfg_r.semi_en        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegTextureMode:  prdata = {30'h0, cfg_r.tex_format};
      RegPageBaseX:    prdata = {22'h0, cfg_r.page_base_x};
      RegPageBaseY:    prdata = {23'h0, cfg_r.page_base_y};
      RegPaletteBaseX: prdata = {22'h0, cfg_r.palette_base_x};
      RegPaletteBaseY: prdata = {23'h0, cfg_r.palette_base_y};
      RegWindowMasks:  prdata = cfg_r.window_masks;
      RegSemiEnable:   prdata = {31'h0, cfg_r.semi_en};
      default:         prdata = '0;
    endcase
  end

  assign q_push   = in_valid && !q_full;
  assign in_stall = q_full;

  ptf_front #(
    .VRAM_COLUMNS (VRAM_COLUMNS),
    .VRAM_ROWS    (VRAM_ROWS)
  ) u_front (
    .cfg           (cfg_r),
    .in_func       (in_func),
    .in_vram_x     (in_vram_x),
    .in_vram_y     (in_vram_y),
    .in_write_data (in_write_data),
    .in_tex_u      (in_tex_u),
    .in_tex_v      (in_tex_v),
    .ent           (front_ent)
  );

  ptf_queue #(
    .WIDTH (EntW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (front_ent),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head_data (q_head)
  );

  ptf_back #(
    .VRAM_COLUMNS (VRAM_COLUMNS),
    .VRAM_ROWS    (VRAM_ROWS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_ent          (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_raw_color  (out_raw_color),
    .out_texel_rgba (out_texel_rgba)
  );

endmodule

// ===== verif/tb_paletted_texel_fetch_core.sv =====
// ----------------------------------------------------------------------------
// tb_paletted_texel_fetch_core
// Self-checking bench for the paletted texel fetch core. Video memory words
// are written through the input channel before any fetch reads them. Every
// fetch result is predicted from a local memory image and the current
// register set, and compared field by field in transfer order. Each register
// setting is loaded over the register port with the block idle. Both channels
// idle and stall at random, and a long output hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_paletted_texel_fetch_core;
  import ptf_pkg::*;

  localparam int ClkHalf       = 6;
  localparam int ClkPeriod     = 2 * ClkHalf;
  localparam int TimeoutCycles = 400000;
  localparam int SettleCycles  = 12;
  localparam int HoldOffCycles = 200;
  localparam int TotalItems    = 1400;
  localparam int Cols          = VramColumnsDef;
  localparam int Rows          = VramRowsDef;

  localparam logic [1:0] ModeReserved = 2'd3;

  typedef struct {
    logic        func;
    logic [9:0]  vram_x;
    logic [8:0]  vram_y;
    logic [15:0] write_data;
    logic [7:0]  tex_u;
    logic [7:0]  tex_v;
  } texel_item_t;

  typedef struct {
    logic [15:0] raw_color;
    logic [31:0] texel_rgba;
  } texel_result_t;

  typedef enum int {StallNone, StallLight, StallHeavy, StallAlternate} stall_pattern_t;

  class texel_fetch_predictor;
    bit [15:0]     vram [Cols*Rows];
    ptf_cfg_t      cfg;
    texel_result_t pending_texels [$];
    int            errors;

    function new();
      cfg = '0;
      cfg.window_masks = WindowMasksRst;
      errors = 0;
    endfunction

    function void set_register(logic [RegIdxW-1:0] idx, logic [31:0] value);
      case (idx)
        RegTextureMode:  cfg.tex_format     = value[1:0];
        RegPageBaseX:    cfg.page_base_x    = value[9:0];
        RegPageBaseY:    cfg.page_base_y    = value[8:0];
        RegPaletteBaseX: cfg.palette_base_x = value[9:0];
        RegPaletteBaseY: cfg.palette_base_y = value[8:0];
        RegWindowMasks:  cfg.window_masks   = value;
        RegSemiEnable:   cfg.semi_en        = value[0];
        default: ;
      endcase
    endfunction

    function int unsigned word_addr(int unsigned col, int unsigned row);
      return (row % Rows) * Cols + (col % Cols);
    endfunction

    function int unsigned window_u(logic [7:0] tex_u);
      return 32'((tex_u & cfg.window_masks[7:0]) | cfg.window_masks[23:16]);
    endfunction

    function int unsigned window_v(logic [7:0] tex_v);
      return 32'((tex_v & cfg.window_masks[15:8]) | cfg.window_masks[31:24]);
    endfunction

    function bit paletted();
      return cfg.tex_format == ModePal4 || cfg.tex_format == ModePal8;
    endfunction

    function int unsigned page_addr(logic [7:0] tex_u, logic [7:0] tex_v);
      int unsigned u;
      int unsigned v;
      u = window_u(tex_u);
      v = window_v(tex_v);
      case (cfg.tex_format)
        ModePal4: return word_addr(cfg.page_base_x + (u >> 2), cfg.page_base_y + v);
        ModePal8: return word_addr(cfg.page_base_x + (u >> 1), cfg.page_base_y + v);
        default:  return word_addr(cfg.page_base_x + u, cfg.page_base_y + v);
      endcase
    endfunction

    function int unsigned palette_addr(int unsigned page_word, logic [7:0] tex_u);
      int unsigned u;
      int unsigned idx;
      u = window_u(tex_u);
      if (cfg.tex_format == ModePal4) begin
        idx = (page_word >> ((u & 3) * 4)) & 'hF;
      end else begin
        idx = (page_word >> ((u & 1) * 8)) & 'hFF;
      end
      return word_addr(cfg.palette_base_x + idx, cfg.palette_base_y);
    endfunction

    function logic [7:0] expand5(logic [4:0] c);
      return {c, c[4:2]};
    endfunction

    function void note_transfer(texel_item_t it);
      int unsigned   pa;
      logic [15:0]   color;
      texel_result_t r;
      if (it.func == FuncWrite) begin
        vram[word_addr(it.vram_x, it.vram_y)] = it.write_data;
        return;
      end
      pa = page_addr(it.tex_u, it.tex_v);
      if (paletted()) begin
        color = vram[palette_addr(vram[pa], it.tex_u)];
      end else begin
        color = vram[pa];
      end
      r.raw_color = color;
      if (color == 16'h0) begin
        r.texel_rgba = '0;
      end else begin
        r.texel_rgba = {(cfg.semi_en && color[15]) ? AlphaHalf : AlphaFull,
                        expand5(color[14:10]), expand5(color[9:5]), expand5(color[4:0])};
      end
      pending_texels.insert(pending_texels.size(), r);
    endfunction

    function void check_texel(logic [15:0] raw, logic [31:0] rgba);
      texel_result_t e;
      if (pending_texels.size() == 0) begin
        errors++;
        $display("%0t: texel expected none actual raw_color %h texel_rgba %h",
                 $time, raw, rgba);
        return;
      end
      e = pending_texels.pop_front();
      if (raw !== e.raw_color) begin
        errors++;
        $display("%0t: raw_color expected %h actual %h", $time, e.raw_color, raw);
      end
      if (rgba !== e.texel_rgba) begin
        errors++;
        $display("%0t: texel_rgba expected %h actual %h", $time, e.texel_rgba, rgba);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid;
  logic                in_stall;
  logic                in_func;
  logic [9:0]          in_vram_x;
  logic [8:0]          in_vram_y;
  logic [15:0]         in_write_data;
  logic [7:0]          in_tex_u;
  logic [7:0]          in_tex_v;
  logic                out_valid;
  logic                out_stall;
  logic [15:0]         out_raw_color;
  logic [31:0]         out_texel_rgba;

  texel_fetch_predictor fetch_pred;
  logic [15:0]          plan_word [Cols*Rows];
  bit                   hold_off_req = 1'b0;
  int                   burst_left = 0;
  int                   items_sent = 0;

  paletted_texel_fetch_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_vram_x      (in_vram_x),
    .in_vram_y      (in_vram_y),
    .in_write_data  (in_write_data),
    .in_tex_u       (in_tex_u),
    .in_tex_v       (in_tex_v),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_raw_color  (out_raw_color),
    .out_texel_rgba (out_texel_rgba)
  );

  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      fetch_pred.check_texel(out_raw_color, out_texel_rgba);
    end
  end

  initial begin
    stall_pattern_t pattern;
    int             left;
    out_stall = 1'b0;
    pattern = StallNone;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall = 1'b1;
        repeat (HoldOffCycles) @(negedge clk);
        out_stall = 1'b0;
        hold_off_req = 1'b0;
      end else begin
        if (left == 0) begin
          pattern = stall_pattern_t'($urandom_range(0, 3));
          left = $urandom_range(16, 96);
        end
        left--;
        case (pattern)
          StallNone:  out_stall = 1'b0;
          StallLight: out_stall = ($urandom_range(0, 3) == 0);
          StallHeavy: out_stall = ($urandom_range(0, 3) != 0);
          default:    out_stall = ~out_stall;
        endcase
      end
    end
  end

  initial begin
    #(ClkPeriod * TimeoutCycles);
    $display("** paletted_texel_fetch_core: FAILED **");
    $finish;
  end

  function automatic texel_item_t write_item(int unsigned col, int unsigned row,
                                             logic [15:0] data);
    texel_item_t it;
    it.func       = FuncWrite;
    it.vram_x     = col[9:0];
    it.vram_y     = row[8:0];
    it.write_data = data;
    it.tex_u      = 8'($urandom);
    it.tex_v      = 8'($urandom);
    return it;
  endfunction

  function automatic texel_item_t fetch_item(logic [7:0] u, logic [7:0] v);
    texel_item_t it;
    it.func       = FuncFetch;
    it.vram_x     = 10'($urandom);
    it.vram_y     = 9'($urandom);
    it.write_data = 16'($urandom);
    it.tex_u      = u;
    it.tex_v      = v;
    return it;
  endfunction

  function automatic logic [15:0] random_colour();
    return ($urandom_range(0, 7) == 0) ? 16'h0 : 16'($urandom);
  endfunction

  function automatic int unsigned pick_field(int unsigned top);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  task automatic issue(texel_item_t it);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        repeat ($urandom_range(1, 8)) begin
          @(negedge clk);
          in_valid = 1'b0;
        end
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    if (it.func == FuncWrite) begin
      plan_word[fetch_pred.word_addr(it.vram_x, it.vram_y)] = it.write_data;
    end
    @(negedge clk);
    in_valid      = 1'b1;
    in_func       = it.func;
    in_vram_x     = it.vram_x;
    in_vram_y     = it.vram_y;
    in_write_data = it.write_data;
    in_tex_u      = it.tex_u;
    in_tex_v      = it.tex_v;
    do @(posedge clk); while (in_stall);
    fetch_pred.note_transfer(it);
    items_sent++;
  endtask

  // write any page or palette word the fetch would read before it was written
  task automatic fetch_with_fill(logic [7:0] u, logic [7:0] v);
    int unsigned pa;
    int unsigned qa;
    pa = fetch_pred.page_addr(u, v);
    if ($isunknown(plan_word[pa])) begin
      issue(write_item(pa % Cols, pa / Cols,
                       fetch_pred.paletted() ? 16'($urandom) : random_colour()));
    end
    if (fetch_pred.paletted()) begin
      qa = fetch_pred.palette_addr(plan_word[pa], u);
      if ($isunknown(plan_word[qa])) begin
        issue(write_item(qa % Cols, qa / Cols, random_colour()));
      end
    end
    issue(fetch_item(u, v));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (fetch_pred.pending_texels.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    fetch_pred.set_register(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic configure(logic [1:0] mode, int unsigned pbx, int unsigned pby,
                           int unsigned qbx, int unsigned qby, logic [31:0] masks,
                           logic semi);
    write_reg(RegTextureMode, 32'(mode));
    write_reg(RegPageBaseX, pbx);
    write_reg(RegPageBaseY, pby);
    write_reg(RegPaletteBaseX, qbx);
    write_reg(RegPaletteBaseY, qby);
    write_reg(RegWindowMasks, masks);
    write_reg(RegSemiEnable, 32'(semi));
  endtask

  task automatic random_config();
    logic [31:0] masks;
    case ($urandom_range(0, 7))
      0, 1:    masks = WindowMasksRst;
      2, 3:    masks = $urandom;
      4, 5:    masks = {8'($urandom), 8'($urandom), 8'h0F, 8'h07};
      6:       masks = 32'h0;
      default: masks = 32'hFFFF_FFFF;
    endcase
    configure(2'($urandom_range(0, 3)), pick_field(Cols - 1), pick_field(Rows - 1),
              pick_field(Cols - 1), pick_field(Rows - 1), masks, 1'($urandom));
  endtask

  task automatic run_phase(int n);
    int stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 15) begin
        issue(write_item($urandom_range(0, Cols - 1), $urandom_range(0, Rows - 1),
                         16'($urandom)));
      end else begin
        fetch_with_fill(8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    int phase_no;
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    in_func       = FuncWrite;
    in_vram_x     = '0;
    in_vram_y     = '0;
    in_write_data = '0;
    in_tex_u      = '0;
    in_tex_v      = '0;
    fetch_pred    = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    issue(write_item(0, 0, 16'h0000));
    issue(write_item(Cols - 1, Rows - 1, 16'hFFFF));
    issue(write_item(Cols - 1, 0, 16'h8000));
    issue(write_item(0, Rows - 1, 16'h7FFF));
    fetch_with_fill(8'h00, 8'h00);
    fetch_with_fill(8'hFF, 8'hFF);
    drain();

    configure(ModeDirect, Cols - 1, Rows - 1, 0, 0, WindowMasksRst, 1'b1);
    fetch_with_fill(8'h00, 8'h00);
    fetch_with_fill(8'h01, 8'h00);
    fetch_with_fill(8'h00, 8'h01);
    fetch_with_fill(8'hFF, 8'hFF);
    drain();

    configure(ModePal8, 1000, 500, Cols - 1, Rows - 1, 32'hFF00_00FF, 1'b0);
    fetch_with_fill(8'h00, 8'h00);
    fetch_with_fill(8'h01, 8'h00);
    fetch_with_fill(8'hFF, 8'h11);
    drain();

    configure(ModeReserved, 512, 256, 0, 0, 32'h0, 1'b1);
    fetch_with_fill(8'hAA, 8'h55);
    drain();

    configure(ModePal4, 1020, 510, 1020, Rows - 1, 32'hFFFF_FFFF, 1'b1);
    fetch_with_fill(8'h00, 8'h00);
    fetch_with_fill(8'h03, 8'h03);
    drain();

    phase_no = 0;
    while (items_sent < TotalItems) begin
      random_config();
      if (phase_no == 2) begin
        hold_off_req = 1'b1;
      end
      run_phase($urandom_range(40, 160));
      drain();
      phase_no++;
    end

    if (fetch_pred.errors == 0 && fetch_pred.pending_texels.size() == 0) begin
      $display("** paletted_texel_fetch_core: PASSED **");
    end else begin
      $display("** paletted_texel_fetch_core: FAILED **");
    end
    $finish;
  end

endmodule
